// ----- rtl/rbrd_pkg.sv -----
// ----------------------------------------------------------------------------
// rbrd_pkg
// Shared types and constants for the byte run-length decoder.
// ----------------------------------------------------------------------------
package rbrd_pkg;

    localparam int COUNT_BITS = 16;
    localparam int LIMIT_BITS = 16;
    localparam int WIDE_BITS  = 33;
    localparam int RUN_BITS   = 6;

    localparam logic [7:0] MARKER_BASE = 8'hC0;

    typedef enum logic [1:0] {
        END_OK    = 2'd0,
        END_FULL  = 2'd1,
        END_TRUNC = 2'd2
    } end_status_t;

    // count unit control
    typedef struct packed {
        logic inc;
        logic clr;
    } cnt_ctl_t;

    // count unit status
    typedef struct packed {
        logic [COUNT_BITS-1:0] cnt;
        logic [COUNT_BITS-1:0] cnt_next;
        logic                  full;
    } cnt_stat_t;

    // limit clamped to what the counter can hold
    function automatic logic [COUNT_BITS-1:0] eff_limit(input logic [LIMIT_BITS-1:0] lim);
        logic [WIDE_BITS-1:0] wlim;
        logic [WIDE_BITS-1:0] cmax;
        begin
            wlim = WIDE_BITS'(lim);
            cmax = (WIDE_BITS'(1) << COUNT_BITS) - WIDE_BITS'(1);
            if (wlim > cmax)
            begin
                wlim = cmax;
            end
            return COUNT_BITS'(wlim);
        end
    endfunction

endpackage

// ----- rtl/rbrd_count_unit.sv -----
// ----------------------------------------------------------------------------
// rbrd_count_unit
// Output byte counter with its increment and limit compare, shared by every
// literal and every repeated byte.
// ----------------------------------------------------------------------------
module rbrd_count_unit
    import rbrd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [LIMIT_BITS-1:0] limit,
    input  cnt_ctl_t              ctl,
    output cnt_stat_t             stat
);

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] count_inc;

    assign count_inc = count_reg + COUNT_BITS'(1);

    always_comb
    begin
        count_next = count_reg;
        if (ctl.clr)
        begin
            count_next = '0;
        end
        else if (ctl.inc)
        begin
            count_next = count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign stat.cnt      = count_reg;
    assign stat.cnt_next = count_inc;
    // a limit of zero is full on the first byte as well
    assign stat.full     = (count_inc >= eff_limit(limit));

endmodule

// ----- rtl/rle_byte_run_decoder_core.sv -----
// ----------------------------------------------------------------------------
// rle_byte_run_decoder_core
// Byte-serial run-length decoder with repeat markers above 0xC0.
//
//   channel | dir | signals                          | content
//   s_      | in  | tvalid tready tdata[7:0] tlast   | source byte, final byte
//   m_      | out | tvalid tready tdata tlast tuser  | decoded byte, count, end
//   cfg_    | in  | we wdata[15:0]                   | destination limit
//
// A literal is emitted as it is taken; a marker waits for its value byte,
// which is then repeated 1 to 63 times, paced by the single count and
// limit-compare unit that handles one emitted byte per cycle unless stalled.
// Reset clears the decode state and sets the limit to 65535.
// A stalled output holds the result and the input until it is taken.
// ----------------------------------------------------------------------------
module rle_byte_run_decoder_core
    import rbrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] total_count
    output logic        m_tlast,
    output logic [2:0]  m_tuser,   // [0] byte_valid, [2:1] end_status
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic                  await_reg, await_next;
    logic                  discard_reg, discard_next;
    logic [RUN_BITS-1:0]   run_reg, run_next;
    logic [7:0]            val_reg, val_next;
    logic                  last_reg, last_next;
    logic [LIMIT_BITS-1:0] limit_reg;

    logic                  ov_reg, ov_next;
    logic [7:0]            ob_reg, ob_next;
    logic                  obv_reg, obv_next;
    logic                  oend_reg, oend_next;
    end_status_t           ost_reg, ost_next;
    logic [15:0]           otot_reg, otot_next;

    cnt_ctl_t              cctl;
    cnt_stat_t             cstat;

    logic                  out_free;
    logic                  accept;
    logic                  emit;
    logic [7:0]            emit_byte;
    logic                  emit_final;
    logic                  emit_src_last;
    logic                  load;

    rbrd_count_unit u_count (
        .clk   (clk),
        .rst_n (rst_n),
        .limit (limit_reg),
        .ctl   (cctl),
        .stat  (cstat)
    );

    assign out_free = !ov_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next    = state_reg;
        await_next    = await_reg;
        discard_next  = discard_reg;
        run_next      = run_reg;
        val_next      = val_reg;
        last_next     = last_reg;
        ob_next       = ob_reg;
        obv_next      = obv_reg;
        oend_next     = oend_reg;
        ost_next      = ost_reg;
        otot_next     = otot_reg;
        cctl          = '0;
        emit          = 1'b0;
        emit_byte     = s_tdata;
        emit_final    = 1'b0;
        emit_src_last = 1'b0;
        load          = 1'b0;

        if (accept)
        begin
            if (discard_reg)
            begin
                if (s_tlast)
                begin
                    discard_next = 1'b0;
                    await_next   = 1'b0;
                    cctl.clr     = 1'b1;
                end
            end
            else if (await_reg)
            begin
                await_next = 1'b0;
                val_next   = s_tdata;
                last_next  = s_tlast;
                state_next = ST_RUN;
            end
            else if (s_tdata > MARKER_BASE)
            begin
                if (s_tlast)
                begin
                    // marker with no value byte behind it
                    load      = 1'b1;
                    ob_next   = 8'd0;
                    obv_next  = 1'b0;
                    oend_next = 1'b1;
                    ost_next  = END_TRUNC;
                    otot_next = 16'(cstat.cnt);
                    cctl.clr  = 1'b1;
                end
                else
                begin
                    await_next = 1'b1;
                    run_next   = RUN_BITS'(s_tdata - MARKER_BASE);
                end
            end
            else
            begin
                emit          = 1'b1;
                emit_byte     = s_tdata;
                emit_final    = s_tlast;
                emit_src_last = s_tlast;
            end
        end
        else if ((state_reg == ST_RUN) && out_free)
        begin
            emit          = 1'b1;
            emit_byte     = val_reg;
            emit_final    = (run_reg == RUN_BITS'(1)) && last_reg;
            emit_src_last = last_reg;
            run_next      = run_reg - RUN_BITS'(1);
            if (cstat.full || (run_reg == RUN_BITS'(1)))
            begin
                state_next = ST_IDLE;
            end
        end

        if (emit)
        begin
            load      = 1'b1;
            ob_next   = emit_byte;
            obv_next  = 1'b1;
            otot_next = 16'(cstat.cnt_next);
            if (cstat.full)
            begin
                oend_next    = 1'b1;
                ost_next     = END_FULL;
                cctl.clr     = 1'b1;
                discard_next = !emit_src_last;
            end
            else if (emit_final)
            begin
                oend_next = 1'b1;
                ost_next  = END_OK;
                cctl.clr  = 1'b1;
            end
            else
            begin
                oend_next = 1'b0;
                ost_next  = END_OK;
                cctl.inc  = 1'b1;
            end
        end

        if (load)
        begin
            ov_next = 1'b1;
        end
        else if (m_tready)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            await_reg   <= 1'b0;
            discard_reg <= 1'b0;
            ov_reg      <= 1'b0;
            limit_reg   <= 16'hFFFF;
        end
        else
        begin
            state_reg   <= state_next;
            await_reg   <= await_next;
            discard_reg <= discard_next;
            ov_reg      <= ov_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg  <= run_next;
        val_reg  <= val_next;
        last_reg <= last_next;
        ob_reg   <= ob_next;
        obv_reg  <= obv_next;
        oend_reg <= oend_next;
        ost_reg  <= ost_next;
        otot_reg <= otot_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {otot_reg, ob_reg};
    assign m_tlast  = oend_reg;
    assign m_tuser  = {ost_reg, obv_reg};

    // a status-only result is always a truncation end
    a_status_only_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !obv_reg) |-> (oend_reg && (ost_reg == END_TRUNC)))
        else $error("status-only result without truncation end");

    // any stream end leaves the byte count cleared
    a_end_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (load && oend_next) |=> (cstat.cnt == '0))
        else $error("count not cleared after stream end");

    // a repeat run never runs while inputs are being dropped or a value byte is awaited
    a_no_run_discard: assert property (@(posedge clk) disable iff (!rst_n)
        !((state_reg == ST_RUN) && (discard_reg || await_reg)))
        else $error("repeat run overlaps discard or marker wait");

    // a full destination returns to idle; later inputs up to the source end are dropped
    a_full_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && cstat.full) |=> (state_reg == ST_IDLE))
        else $error("repeat run continued past full destination");

endmodule
